// ===== sv/dlpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dlpw_pkg
// shared types and constants of the diagonal line point walker
// ----------------------------------------------------------------------------
package dlpw_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int MAX_POINTS_DEF  = 64;
  localparam int NUM_AXES        = 4;
  localparam int SPAN_W          = 6;   // span of an emitted line is below 64
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_LINE = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // classified segment handed from the front to the back
  typedef struct packed {
    status_t                     status;
    logic [SPAN_W-1:0]           span;
    dir_t [NUM_AXES-1:0]         dir;
  } cmd_t;

endpackage

// ===== sv/dlpw_if.sv =====
// ----------------------------------------------------------------------------
// dlpw_seg_if / dlpw_pt_if
// valid/ready channels for segments in and points out
// ----------------------------------------------------------------------------
interface dlpw_seg_if #(parameter int COORD_BITS = dlpw_pkg::COORD_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  start_z;
  logic signed [COORD_BITS-1:0]  start_a;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic signed [COORD_BITS-1:0]  end_z;
  logic signed [COORD_BITS-1:0]  end_a;

  modport source (output valid, start_x, start_y, start_z, start_a,
                  end_x, end_y, end_z, end_a, input ready);
  modport sink   (input valid, start_x, start_y, start_z, start_a,
                  end_x, end_y, end_z, end_a, output ready);
endinterface

interface dlpw_pt_if #(parameter int COORD_BITS = dlpw_pkg::COORD_BITS_DEF);
  import dlpw_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic signed [COORD_BITS-1:0]  point_z;
  logic signed [COORD_BITS-1:0]  point_a;
  status_t                       status;
  logic                          last;

  modport source (output valid, point_x, point_y, point_z, point_a, status, last,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_a, status, last,
                  output ready);
endinterface

// ===== sv/dlpw_front.sv =====
// ----------------------------------------------------------------------------
// dlpw_front
// takes segments, measures per-axis distance and classifies the line
// ----------------------------------------------------------------------------
module dlpw_front #(
  parameter int COORD_BITS = dlpw_pkg::COORD_BITS_DEF,
  parameter int MAX_POINTS = dlpw_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dlpw_seg_if.sink                      seg,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic signed [COORD_BITS-1:0]  push_start [dlpw_pkg::NUM_AXES],
  output dlpw_pkg::cmd_t                push_cmd
);
  import dlpw_pkg::*;

  localparam int CMP_W = (COORD_BITS > 7) ? COORD_BITS : 7;

  logic signed [COORD_BITS-1:0] s_in    [NUM_AXES];
  logic signed [COORD_BITS-1:0] e_in    [NUM_AXES];
  logic signed [COORD_BITS:0]   diff    [NUM_AXES];
  logic        [COORD_BITS-1:0] dist_in [NUM_AXES];
  dir_t                         dir_in  [NUM_AXES];

  logic                         hold_valid;
  logic signed [COORD_BITS-1:0] hold_start [NUM_AXES];
  logic        [COORD_BITS-1:0] hold_dist  [NUM_AXES];
  dir_t                         hold_dir   [NUM_AXES];

  logic [COORD_BITS-1:0] span01, span23, span;
  logic                  line_ok, too_long;
  logic                  accept;

  assign s_in[0] = seg.start_x;
  assign s_in[1] = seg.start_y;
  assign s_in[2] = seg.start_z;
  assign s_in[3] = seg.start_a;
  assign e_in[0] = seg.end_x;
  assign e_in[1] = seg.end_y;
  assign e_in[2] = seg.end_z;
  assign e_in[3] = seg.end_a;

  assign seg.ready = !hold_valid || push_ready;
  assign accept    = seg.valid && seg.ready;

  // signed difference one bit wider, magnitude always fits the coordinate width
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] = (COORD_BITS+1)'(e_in[i]) - (COORD_BITS+1)'(s_in[i]);
      if (diff[i][COORD_BITS]) begin
        dist_in[i] = COORD_BITS'(-diff[i]);
        dir_in[i]  = DIR_DOWN;
      end else begin
        dist_in[i] = COORD_BITS'(diff[i]);
        dir_in[i]  = (diff[i] == '0) ? DIR_HOLD : DIR_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_start <= s_in;
      hold_dist  <= dist_in;
      hold_dir   <= dir_in;
    end
  end

  // longest axis, then every moving axis must match it
  always_comb begin
    span01 = (hold_dist[0] > hold_dist[1]) ? hold_dist[0] : hold_dist[1];
    span23 = (hold_dist[2] > hold_dist[3]) ? hold_dist[2] : hold_dist[3];
    span   = (span01 > span23) ? span01 : span23;
    line_ok = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (hold_dist[i] != '0 && hold_dist[i] != span) line_ok = 1'b0;
    end
    too_long = CMP_W'(span) >= CMP_W'(MAX_POINTS);
  end

  always_comb begin
    push_cmd.span = SPAN_W'(span);
    for (int i = 0; i < NUM_AXES; i++) push_cmd.dir[i] = hold_dir[i];
    priority if (!line_ok) begin
      push_cmd.status = ST_NOT_LINE;
    end else if (too_long) begin
      push_cmd.status = ST_TOO_LONG;
    end else begin
      push_cmd.status = ST_OK;
    end
  end

  assign push_valid = hold_valid;
  assign push_start = hold_start;

endmodule

// ===== sv/dlpw_queue.sv =====
// ----------------------------------------------------------------------------
// dlpw_queue
// short first-in first-out buffer between front and back
// ----------------------------------------------------------------------------
module dlpw_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = dlpw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/dlpw_back.sv =====
// ----------------------------------------------------------------------------
// dlpw_back
// walks a classified segment into out_pt, one point per cycle unless pt stalls
// ----------------------------------------------------------------------------
module dlpw_back #(
  parameter int COORD_BITS = dlpw_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic signed [COORD_BITS-1:0]  pop_start [dlpw_pkg::NUM_AXES],
  input  dlpw_pkg::cmd_t                pop_cmd,
  dlpw_pt_if.source                     pt
);
  import dlpw_pkg::*;

  logic                         busy;
  logic signed [COORD_BITS-1:0] cur    [NUM_AXES];
  dir_t                         dir    [NUM_AXES];
  logic [SPAN_W-1:0]            remain;

  logic                         out_valid;
  logic signed [COORD_BITS-1:0] out_pt [NUM_AXES];
  status_t                      out_status;
  logic                         out_last;

  logic adv, load;

  function automatic logic signed [COORD_BITS-1:0] step_coord(
    input logic signed [COORD_BITS-1:0] c,
    input dir_t                         d
  );
    logic signed [COORD_BITS-1:0] r;
    unique case (d)
      DIR_UP:   r = c + COORD_BITS'(1);
      DIR_DOWN: r = c - COORD_BITS'(1);
      default:  r = c;
    endcase
    return r;
  endfunction

  assign adv       = !out_valid || pt.ready;
  assign pop_ready = !busy && adv;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= busy || pop_valid;
      if (busy) begin
        busy <= remain != '0;
      end else if (pop_valid) begin
        busy <= pop_cmd.status == ST_OK && pop_cmd.span != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && busy) begin
      out_pt     <= cur;
      out_status <= ST_OK;
      out_last   <= remain == '0;
      remain     <= remain - 1'b1;
      for (int i = 0; i < NUM_AXES; i++) cur[i] <= step_coord(cur[i], dir[i]);
    end else if (load) begin
      out_status <= pop_cmd.status;
      if (pop_cmd.status == ST_OK) begin
        out_pt   <= pop_start;
        out_last <= pop_cmd.span == '0;
        remain   <= pop_cmd.span - 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
          dir[i] <= pop_cmd.dir[i];
          cur[i] <= step_coord(pop_start[i], pop_cmd.dir[i]);
        end
      end else begin
        for (int i = 0; i < NUM_AXES; i++) out_pt[i] <= '0;
        out_last <= 1'b1;
      end
    end
  end

  assign pt.valid   = out_valid;
  assign pt.point_x = out_pt[0];
  assign pt.point_y = out_pt[1];
  assign pt.point_z = out_pt[2];
  assign pt.point_a = out_pt[3];
  assign pt.status  = out_status;
  assign pt.last    = out_last;

endmodule

// ===== sv/diagonal_line_point_walker_top.sv =====
// a segment passes the input stage, the queue and the output register on its way to pt
// a line of span d yields d + 1 points on pt, up to 64 points, and a rejected segment
//   yields a single result; dlpw_back takes no new segment while it still walks one
// up to three segments wait in the input stage and the two-entry queue during a walk
// reset: synchronous, active high; empties the input stage, the queue and the output
// ----------------------------------------------------------------------------
// diagonal_line_point_walker_top
// rasterises axis-aligned and 45-degree lines between two 4-d points
// ----------------------------------------------------------------------------
module diagonal_line_point_walker_top #(
  parameter int COORD_BITS = dlpw_pkg::COORD_BITS_DEF,
  parameter int MAX_POINTS = dlpw_pkg::MAX_POINTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dlpw_seg_if.sink   seg,
  dlpw_pt_if.source  pt
);
  import dlpw_pkg::*;

  // queue word: four start coordinates above the classified command
  localparam int CMD_W = $bits(cmd_t);
  localparam int DW    = NUM_AXES * COORD_BITS + CMD_W;

  logic                         push_valid, push_ready;
  logic signed [COORD_BITS-1:0] push_start [NUM_AXES];
  cmd_t                         push_cmd;
  logic [DW-1:0]                push_data;

  logic                         pop_valid, pop_ready;
  logic [DW-1:0]                pop_data;
  logic signed [COORD_BITS-1:0] pop_start [NUM_AXES];
  cmd_t                         pop_cmd;

  // front: input register, distance per axis, line check
  dlpw_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_start (push_start),
    .push_cmd   (push_cmd)
  );

  // pack / unpack the queue word
  always_comb begin
    push_data[CMD_W-1:0] = push_cmd;
    for (int i = 0; i < NUM_AXES; i++) begin
      push_data[CMD_W + i*COORD_BITS +: COORD_BITS] = push_start[i];
    end
  end

  always_comb begin
    pop_cmd = cmd_t'(pop_data[CMD_W-1:0]);
    for (int i = 0; i < NUM_AXES; i++) begin
      pop_start[i] = pop_data[CMD_W + i*COORD_BITS +: COORD_BITS];
    end
  end

  // decouples classification from the walk so each side stalls on its own
  dlpw_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: one point per cycle into the output register, unless pt stalls
  dlpw_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_start (pop_start),
    .pop_cmd   (pop_cmd),
    .pt        (pt)
  );

endmodule

// ===== sv/dlpw_checker.sv =====
// ----------------------------------------------------------------------------
// dlpw_checker
// port-level checks on the point walker, bound to the top level
// ----------------------------------------------------------------------------
module dlpw_checker #(
  parameter int COORD_BITS = dlpw_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_BITS-1:0]  point_x,
  input logic signed [COORD_BITS-1:0]  point_y,
  input logic signed [COORD_BITS-1:0]  point_z,
  input logic signed [COORD_BITS-1:0]  point_a,
  input dlpw_pkg::status_t             status,
  input logic                          last
);
  import dlpw_pkg::*;

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

  // a rejected segment gives a single zero result
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      last && point_x == '0 && point_y == '0 && point_z == '0 && point_a == '0)
    else $error("rejected segment result malformed");

  // points of one line follow each other without a gap
  a_walk_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && status == ST_OK && !last |=>
      out_valid && status == ST_OK)
    else $error("gap or status change inside a line");

endmodule

bind diagonal_line_point_walker_top dlpw_checker #(
  .COORD_BITS (COORD_BITS)
) u_dlpw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pt.valid),
  .out_ready (pt.ready),
  .point_x   (pt.point_x),
  .point_y   (pt.point_y),
  .point_z   (pt.point_z),
  .point_a   (pt.point_a),
  .status    (pt.status),
  .last      (pt.last)
);
